// File: hdl/epd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epd_pkg: shared constants, types and tables for the endless pot decoder
// Holds the field widths, the pot scale, the CORDIC arctangent table and the
// status type that the queue hands to its neighbors.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int WIPER_W        = 10;
  localparam int POS_W          = 11;
  localparam int STEP_W         = 11;
  localparam int POT_MAX        = 1024;
  localparam int HALF_POT       = POT_MAX / 2;
  localparam int PHASE_BITS_DEF = 16;

  localparam int CORDIC_ITERS = 28;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_W     = 43;
  localparam int Z_W          = 32;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [Z_W-1:0] atan_val(input int unsigned i);
    logic [Z_W-1:0] r;
    case (i)
      0:       r = 32'd536870912;
      1:       r = 32'd316933406;
      2:       r = 32'd167458907;
      3:       r = 32'd85004756;
      4:       r = 32'd42667331;
      5:       r = 32'd21354465;
      6:       r = 32'd10679838;
      7:       r = 32'd5340245;
      8:       r = 32'd2670163;
      9:       r = 32'd1335087;
      10:      r = 32'd667544;
      11:      r = 32'd333772;
      12:      r = 32'd166886;
      13:      r = 32'd83443;
      14:      r = 32'd41722;
      15:      r = 32'd20861;
      16:      r = 32'd10430;
      17:      r = 32'd5215;
      18:      r = 32'd2608;
      19:      r = 32'd1304;
      20:      r = 32'd652;
      21:      r = 32'd326;
      22:      r = 32'd163;
      23:      r = 32'd81;
      24:      r = 32'd41;
      25:      r = 32'd20;
      26:      r = 32'd10;
      27:      r = 32'd5;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/endless_pot_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// endless_pot_decoder: two-wiper endless potentiometer decoder
// Angle of the wiper pair by pipelined CORDIC, then absolute position,
// wrapped position step and signed linear step.
// ----------------------------------------------------------------------------
// One request per clock cycle while the pipeline is not held. Each wiper pair
// goes through an input register and a 28-stage CORDIC pipeline (one vectoring
// iteration per stage), lands in a 4-entry queue and is then taken by the
// tracker, which updates its kept state and loads the output register in the
// same cycle. The pipeline holds as a whole only while its last stage has a
// request and the queue is full; the tracker stalls only on out_ready. The
// first result after reset uses zero for the previous wipers, phase and
// position.
// ----------------------------------------------------------------------------
module endless_pot_decoder
  import epd_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [WIPER_W-1:0] in_wiper_a,
  input  wire logic [WIPER_W-1:0] in_wiper_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [POS_W-1:0]        out_position,
  output logic [STEP_W-1:0]       out_position_step,
  output logic [STEP_W-1:0]       out_linear_step
);

  // queue entry: wipers, phase in turns, absolute position
  localparam int ENTRY_W = 2 * WIPER_W + PHASE_BITS + POS_W;

  fifo_status_t       q_status;
  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_push_data;
  logic [ENTRY_W-1:0] q_head_data;

  // angle front end: accept, rotate, classify quadrant
  epd_front #(
    .PHASE_BITS (PHASE_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .wiper_a   (in_wiper_a),
    .wiper_b   (in_wiper_b),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  // decouple the two sides
  epd_fifo #(
    .ENTRY_W (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head_data),
    .status    (q_status)
  );

  // tracker: step, direction, half-step remainder, output register
  epd_back #(
    .PHASE_BITS (PHASE_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .q_data        (q_head_data),
    .q_pop         (q_pop),
    .res_valid     (out_valid),
    .res_ready     (out_ready),
    .position      (out_position),
    .position_step (out_position_step),
    .linear_step   (out_linear_step)
  );

endmodule
`default_nettype wire

// File: hdl/epd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epd_front: CORDIC angle pipeline
// Takes wiper pairs, runs one vectoring CORDIC iteration per stage, and turns
// the angle into a phase and an absolute position for the queue.
// ----------------------------------------------------------------------------
module epd_front
  import epd_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int ENTRY_W    = 2 * WIPER_W + PHASE_BITS + POS_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire logic [WIPER_W-1:0] wiper_a,
  input  wire logic [WIPER_W-1:0] wiper_b,
  input  wire fifo_status_t       q_status,
  output logic                    q_push,
  output logic [ENTRY_W-1:0]      q_data
);

  localparam int NST     = CORDIC_ITERS + 1;
  localparam int PAD_W   = CORDIC_W - WIPER_W - CORDIC_FRAC;
  localparam int PROD_W  = PHASE_BITS + 1 + POS_W;
  localparam logic [Z_W:0] RND = (Z_W + 1)'(1) << (31 - PHASE_BITS);
  localparam logic [Z_W:0] Q_U = (Z_W + 1)'(1) << (PHASE_BITS - 2);
  localparam logic signed [PHASE_BITS:0] H_S = (PHASE_BITS + 1)'(1) << (PHASE_BITS - 1);

  logic [NST-1:0]                    v_r;
  logic signed [CORDIC_W-1:0]        x_r [NST];
  logic signed [CORDIC_W-1:0]        y_r [NST];
  logic signed [Z_W-1:0]             z_r [NST];
  logic [WIPER_W-1:0]                a_r [NST];
  logic [WIPER_W-1:0]                b_r [NST];
  logic [NST-1:0]                    ux0_r;
  logic [NST-1:0]                    uy0_r;

  logic signed [CORDIC_W-1:0]        x_nxt [CORDIC_ITERS];
  logic signed [CORDIC_W-1:0]        y_nxt [CORDIC_ITERS];
  logic signed [Z_W-1:0]             z_nxt [CORDIC_ITERS];

  logic                              adv;
  logic [WIPER_W-1:0]                ux;
  logic [WIPER_W-1:0]                uy;

  logic [Z_W-1:0]                    z_clamp;
  logic [Z_W:0]                      z_rnd;
  logic [Z_W:0]                      t_full;
  logic [PHASE_BITS-2:0]             theta;
  logic signed [PHASE_BITS:0]        theta_e;
  logic signed [PHASE_BITS:0]        ps;
  logic [PHASE_BITS:0]               uoff;
  logic [PROD_W-1:0]                 prod;
  logic                              x_pos;
  logic                              y_pos;

  // hold the whole pipeline when the tail has a request and the queue is full
  assign adv       = !(v_r[NST-1] && q_status.full);
  assign req_ready = adv;

  assign ux = (wiper_b >= WIPER_W'(HALF_POT)) ? wiper_b - WIPER_W'(HALF_POT)
                                              : WIPER_W'(HALF_POT) - wiper_b;
  assign uy = (wiper_a >= WIPER_W'(HALF_POT)) ? wiper_a - WIPER_W'(HALF_POT)
                                              : WIPER_W'(HALF_POT) - wiper_a;

  always_comb begin
    for (int k = 0; k < CORDIC_ITERS; k++) begin
      if (!y_r[k][CORDIC_W-1]) begin
        x_nxt[k] = x_r[k] + (y_r[k] >>> k);
        y_nxt[k] = y_r[k] - (x_r[k] >>> k);
        z_nxt[k] = z_r[k] + $signed(atan_val(k));
      end else begin
        x_nxt[k] = x_r[k] - (y_r[k] >>> k);
        y_nxt[k] = y_r[k] + (x_r[k] >>> k);
        z_nxt[k] = z_r[k] - $signed(atan_val(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]   <= $signed({{PAD_W{1'b0}}, ux, {CORDIC_FRAC{1'b0}}});
      y_r[0]   <= $signed({{PAD_W{1'b0}}, uy, {CORDIC_FRAC{1'b0}}});
      z_r[0]   <= '0;
      a_r[0]   <= wiper_a;
      b_r[0]   <= wiper_b;
      ux0_r[0] <= (ux == '0);
      uy0_r[0] <= (uy == '0);
      for (int k = 0; k < CORDIC_ITERS; k++) begin
        x_r[k+1]   <= x_nxt[k];
        y_r[k+1]   <= y_nxt[k];
        z_r[k+1]   <= z_nxt[k];
        a_r[k+1]   <= a_r[k];
        b_r[k+1]   <= b_r[k];
        ux0_r[k+1] <= ux0_r[k];
        uy0_r[k+1] <= uy0_r[k];
      end
    end
  end

  // clamp at zero, round half up to phase units, clamp at a quarter turn
  always_comb begin
    z_clamp = z_r[NST-1][Z_W-1] ? '0 : z_r[NST-1];
    z_rnd   = {1'b0, z_clamp} + RND;
    t_full  = z_rnd >> (32 - PHASE_BITS);
    if (uy0_r[NST-1]) begin
      theta = '0;
    end else if (ux0_r[NST-1] || (t_full > Q_U)) begin
      theta = Q_U[PHASE_BITS-2:0];
    end else begin
      theta = t_full[PHASE_BITS-2:0];
    end
    theta_e = $signed({2'b00, theta});
    x_pos   = (b_r[NST-1] >= WIPER_W'(HALF_POT));
    y_pos   = (a_r[NST-1] >= WIPER_W'(HALF_POT));
    if (x_pos) begin
      ps = y_pos ? theta_e : -theta_e;
    end else begin
      ps = y_pos ? (H_S - theta_e) : (theta_e - H_S);
    end
    uoff = ps + H_S;
    prod = PROD_W'(uoff) * PROD_W'(POT_MAX);
  end

  assign q_push = adv && v_r[NST-1];
  assign q_data = {a_r[NST-1], b_r[NST-1], ps[PHASE_BITS-1:0], prod[PHASE_BITS +: POS_W]};

endmodule
`default_nettype wire

// File: hdl/epd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epd_fifo: request queue between angle pipeline and tracker
// Small register queue; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module epd_fifo
  import epd_pkg::*;
#(
  parameter int ENTRY_W = 2 * WIPER_W + PHASE_BITS_DEF + POS_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [ENTRY_W-1:0] push_data,
  input  wire logic               pop,
  output logic [ENTRY_W-1:0]      head_data,
  output fifo_status_t            status
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [ENTRY_W-1:0] mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_data    = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/epd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epd_back: position and linear step tracker
// Pops one request per cycle while the queue has one and no result is stalled
// on res_ready, updates the kept state and loads the result register.
// ----------------------------------------------------------------------------
module epd_back
  import epd_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int ENTRY_W    = 2 * WIPER_W + PHASE_BITS + POS_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fifo_status_t       q_status,
  input  wire logic [ENTRY_W-1:0] q_data,
  output logic                    q_pop,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic [POS_W-1:0]        position,
  output logic [STEP_W-1:0]       position_step,
  output logic [STEP_W-1:0]       linear_step
);

  localparam int TOT_W = WIPER_W + 2;
  localparam logic signed [POS_W:0] HALF_S = (POS_W + 1)'(HALF_POT);
  localparam logic signed [POS_W:0] MAX_S  = (POS_W + 1)'(POT_MAX);

  logic [WIPER_W-1:0]        a;
  logic [WIPER_W-1:0]        b;
  logic [PHASE_BITS-1:0]     phase;
  logic [POS_W-1:0]          pos;

  logic [WIPER_W-1:0]        last_a_r;
  logic [WIPER_W-1:0]        last_b_r;
  logic [PHASE_BITS-1:0]     last_phase_r;
  logic [POS_W-1:0]          last_pos_r;
  logic signed [1:0]         rem_r;
  logic signed [1:0]         rem_nxt;

  logic                      res_valid_r;
  logic [POS_W-1:0]          position_r;
  logic [STEP_W-1:0]         position_step_r;
  logic [STEP_W-1:0]         linear_step_r;

  logic signed [POS_W:0]     step_raw;
  logic signed [POS_W:0]     step;
  logic [PHASE_BITS-1:0]     dphase;
  logic [WIPER_W-1:0]        da;
  logic [WIPER_W-1:0]        db;
  logic [WIPER_W-1:0]        m;
  logic signed [TOT_W-1:0]   m_s;
  logic signed [TOT_W-1:0]   total;
  logic signed [TOT_W-1:0]   total_adj;
  logic signed [TOT_W-1:0]   emit;

  assign {a, b, phase, pos} = q_data;
  assign q_pop = !q_status.empty && (!res_valid_r || res_ready);

  always_comb begin
    step_raw = $signed({1'b0, pos}) - $signed({1'b0, last_pos_r});
    if (step_raw > HALF_S) begin
      step = step_raw - MAX_S;
    end else if (step_raw < -HALF_S) begin
      step = step_raw + MAX_S;
    end else begin
      step = step_raw;
    end

    dphase = phase - last_phase_r;

    da = (a >= last_a_r) ? a - last_a_r : last_a_r - a;
    db = (b >= last_b_r) ? b - last_b_r : last_b_r - b;
    m  = (da < db) ? da : db;

    // half-turn difference counts as negative, zero as positive
    m_s       = dphase[PHASE_BITS-1] ? -$signed({2'b00, m}) : $signed({2'b00, m});
    total     = $signed({{(TOT_W-2){rem_r[1]}}, rem_r}) + m_s;
    // truncate toward zero
    total_adj = total + $signed({{(TOT_W-1){1'b0}}, total[TOT_W-1]});
    emit      = total_adj >>> 1;
    if (!total[0]) begin
      rem_nxt = 2'sd0;
    end else begin
      rem_nxt = total[TOT_W-1] ? -2'sd1 : 2'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r  <= 1'b0;
      last_a_r     <= '0;
      last_b_r     <= '0;
      last_phase_r <= '0;
      last_pos_r   <= '0;
      rem_r        <= '0;
    end else begin
      if (q_pop) begin
        res_valid_r  <= 1'b1;
        last_a_r     <= a;
        last_b_r     <= b;
        last_phase_r <= phase;
        last_pos_r   <= pos;
        rem_r        <= rem_nxt;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      position_r      <= pos;
      position_step_r <= step[STEP_W-1:0];
      linear_step_r   <= emit[STEP_W-1:0];
    end
  end

  assign res_valid     = res_valid_r;
  assign position      = position_r;
  assign position_step = position_step_r;
  assign linear_step   = linear_step_r;

endmodule
`default_nettype wire

// File: hdl/epd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epd_checker: port-level checks for the endless pot decoder
// Watches the result channel for stall behavior and value ranges.
// ----------------------------------------------------------------------------
module epd_checker
  import epd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [WIPER_W-1:0] in_wiper_a,
  input wire logic [WIPER_W-1:0] in_wiper_b,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [POS_W-1:0]   out_position,
  input wire logic [STEP_W-1:0]  out_position_step,
  input wire logic [STEP_W-1:0]  out_linear_step
);

  logic in_req;
  assign in_req = in_valid && in_ready && (in_wiper_a == in_wiper_a)
                  && (in_wiper_b == in_wiper_b);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_position) && $stable(out_position_step)
                                && $stable(out_linear_step))
    else $error("stalled result changed");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position <= POS_W'(POT_MAX))
    else $error("position beyond pot range");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_position_step) <= 11'sd512)
                  && ($signed(out_position_step) >= -11'sd512)
                  && ($signed(out_linear_step) <= 11'sd512)
                  && ($signed(out_linear_step) >= -11'sd512))
    else $error("step beyond half range");

  // pipeline is empty right after reset, so no result can follow at once
  a_no_early_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid || !in_req)
    else $error("result right after reset");

endmodule

bind endless_pot_decoder epd_checker u_epd_checker (.*);
`default_nettype wire

// File: dv/endless_pot_decoder_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// endless_pot_decoder_chk: result checker for the endless pot decoder
// Watches both channels. Predicts the decode of every accepted wiper request
// and compares each result leaving the block, field by field, in order.
// ----------------------------------------------------------------------------
module endless_pot_decoder_chk
  import epd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [WIPER_W-1:0] in_wiper_a,
  input  logic [WIPER_W-1:0] in_wiper_b,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [POS_W-1:0]   out_position,
  input  logic [STEP_W-1:0]  out_position_step,
  input  logic [STEP_W-1:0]  out_linear_step,
  output int                 fail_count,
  output int                 decodes_in_flight
);

  localparam int     PH_BITS    = PHASE_BITS_DEF;
  localparam longint PH_HALF    = longint'(1) << (PH_BITS - 1);
  localparam longint PH_QUARTER = longint'(1) << (PH_BITS - 2);

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [STEP_W-1:0] position_step;
    logic [STEP_W-1:0] linear_step;
  } decode_result_t;

  // atan(2^-i) in units of 2^-32 turn
  longint atan_turns [CORDIC_ITERS];

  logic [WIPER_W-1:0] prev_wiper_a;
  logic [WIPER_W-1:0] prev_wiper_b;
  logic [PH_BITS-1:0] prev_phase;
  int                 half_rem;
  longint             prev_position;
  decode_result_t     awaited_decodes [$];

  initial begin
    atan_turns = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                   81, 41, 20, 10, 5};
  end

  // first-quadrant angle of (ux, uy) in phase units, 0..quarter turn
  function automatic longint vector_angle(input longint ux, input longint uy);
    longint x, y, z, xs, ys, t;
    if (uy == 0) return 0;
    if (ux == 0) return PH_QUARTER;
    x = ux <<< CORDIC_FRAC;
    y = uy <<< CORDIC_FRAC;
    z = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_turns[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_turns[i];
      end
    end
    if (z < 0) z = 0;
    t = (z + (longint'(1) << (31 - PH_BITS))) >>> (32 - PH_BITS);
    if (t > PH_QUARTER) t = PH_QUARTER;
    return t;
  endfunction

  task automatic decode_wipers(input logic [WIPER_W-1:0] a, input logic [WIPER_W-1:0] b,
                               output decode_result_t r);
    longint             x, y, theta, ps, pos, step;
    logic [PH_BITS-1:0] phase, dphase;
    int                 da, db, m, total, whole;
    y = longint'(a) - HALF_POT;
    x = longint'(b) - HALF_POT;
    theta = vector_angle(x < 0 ? -x : x, y < 0 ? -y : y);
    if (x >= 0) ps = (y >= 0) ? theta : -theta;
    else        ps = (y >= 0) ? (PH_HALF - theta) : (theta - PH_HALF);

    pos  = ((ps + PH_HALF) * POT_MAX) >>> PH_BITS;
    step = pos - prev_position;
    if (step > HALF_POT)       step = step - POT_MAX;
    else if (step < -HALF_POT) step = step + POT_MAX;

    // half a turn of phase change counts as backward
    phase  = ps[PH_BITS-1:0];
    dphase = phase - prev_phase;

    da = int'(a) - int'(prev_wiper_a);
    db = int'(b) - int'(prev_wiper_b);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    m     = (da < db) ? da : db;
    total = half_rem + (dphase[PH_BITS-1] ? -m : m);
    whole = total / 2;
    half_rem = total - 2 * whole;

    prev_wiper_a  = a;
    prev_wiper_b  = b;
    prev_phase    = phase;
    prev_position = pos;

    r.position      = pos[POS_W-1:0];
    r.position_step = step[STEP_W-1:0];
    r.linear_step   = whole[STEP_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    decode_result_t want;
    if (!rst_n) begin
      prev_wiper_a  = '0;
      prev_wiper_b  = '0;
      prev_phase    = '0;
      half_rem      = 0;
      prev_position = 0;
      awaited_decodes.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_wipers(in_wiper_a, in_wiper_b, want);
        awaited_decodes.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (awaited_decodes.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = awaited_decodes.pop_front();
          if (out_position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_position);
            fail_count++;
          end
          if (out_position_step !== want.position_step) begin
            $error("position_step: expected %0d, actual %0d",
                   $signed(want.position_step), $signed(out_position_step));
            fail_count++;
          end
          if (out_linear_step !== want.linear_step) begin
            $error("linear_step: expected %0d, actual %0d",
                   $signed(want.linear_step), $signed(out_linear_step));
            fail_count++;
          end
        end
      end
    end
    decodes_in_flight = awaited_decodes.size();
  end

endmodule

// File: dv/endless_pot_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// endless_pot_decoder_tb: stimulus and verdict for the endless pot decoder
// Drives wiper requests through directed corners, a back-pressure fill and
// long random sequences, mostly smooth rotations of a two-wiper pot, while
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module endless_pot_decoder_tb;
  import epd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_ITEMS  = 150;  // tail of the run with no idling at all
  localparam int FILL_ITEMS   = 60;
  localparam int LONG_HOLD    = 240;  // receiver hold-off, well past the block's depth
  localparam int DRAIN_CYCLES = 40;   // idle time after the last result before the verdict

  typedef enum int {SEG_ROTATE, SEG_UNIFORM, SEG_CORNER} seg_kind_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic [WIPER_W-1:0] in_wiper_a  = '0;
  logic [WIPER_W-1:0] in_wiper_b  = '0;
  logic               out_ready   = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [POS_W-1:0]   out_position;
  logic [STEP_W-1:0]  out_position_step;
  logic [STEP_W-1:0]  out_linear_step;

  int fail_count;
  int decodes_in_flight;
  int cycle_count;
  bit idle_en   = 1'b0;  // allow random idle bursts on both sides
  bit long_hold = 1'b0;  // ask the receiver for one long hold-off

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  endless_pot_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_wiper_a       (in_wiper_a),
    .in_wiper_b       (in_wiper_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_position_step(out_position_step),
    .out_linear_step  (out_linear_step)
  );

  endless_pot_decoder_chk u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_wiper_a       (in_wiper_a),
    .in_wiper_b       (in_wiper_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_position_step(out_position_step),
    .out_linear_step  (out_linear_step),
    .fail_count       (fail_count),
    .decodes_in_flight(decodes_in_flight)
  );

  // Offer one request at the falling edge, hold it until the block takes it,
  // then maybe drop valid for a short idle burst. Valid is never lowered and
  // raised in the same step: the next call only raises it again later.
  task automatic send_pair(input logic [WIPER_W-1:0] a, input logic [WIPER_W-1:0] b);
    in_valid   <= 1'b1;
    in_wiper_a <= a;
    in_wiper_b <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Triangle wiper shape of a real endless pot, one period per 2048 steps.
  function automatic logic [WIPER_W-1:0] wiper_shape(input int p);
    int q;
    q = p & 2047;
    return (q < 1024) ? q[WIPER_W-1:0] : 10'(2047 - q);
  endfunction

  // Values at and around the ends and the centre of the wiper range.
  function automatic logic [WIPER_W-1:0] corner_value();
    case ($urandom_range(0, 6))
      0:       return 10'd0;
      1:       return 10'd1;
      2:       return 10'd511;
      3:       return 10'd512;
      4:       return 10'd513;
      5:       return 10'd1022;
      default: return 10'd1023;
    endcase
  endfunction

  // Receiver: short random stalls while idling is on, one long hold-off on
  // request, otherwise always ready.
  initial begin : receiver
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run with an error verdict once the cycle limit is reached.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("endless_pot_decoder_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int                 sent;
    int                 seg_len;
    int                 rot;
    seg_kind_t          seg;
    logic [WIPER_W-1:0] a, b;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners. Start at the centre, then repeat it so the phase
    // does not move (a zero difference counts forward).
    idle_en = 1'b1;
    send_pair(10'd512, 10'd512);
    send_pair(10'd512, 10'd512);
    // Negative b axis: exactly half a turn, top position, and a half-turn
    // jump from the centre that counts backward.
    send_pair(10'd512, 10'd0);
    send_pair(10'd512, 10'd1023);
    // On the a axis: exactly a quarter turn either way.
    send_pair(10'd0,    10'd512);
    send_pair(10'd1023, 10'd512);
    // Full-scale corners and big moves for the largest linear steps.
    send_pair(10'd0,    10'd0);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd0,    10'd1023);
    send_pair(10'd1023, 10'd0);
    send_pair(10'd0,    10'd0);
    // One code off the centre in each direction.
    send_pair(10'd513, 10'd512);
    send_pair(10'd511, 10'd512);
    send_pair(10'd512, 10'd513);
    send_pair(10'd512, 10'd511);
    // Angles just off the axes and just either side of half a turn.
    send_pair(10'd513,  10'd1023);
    send_pair(10'd1023, 10'd513);
    send_pair(10'd511,  10'd0);
    send_pair(10'd513,  10'd0);
    send_pair(10'd511,  10'd0);

    // Pause the sender until every result is back.
    in_valid <= 1'b0;
    wait (decodes_in_flight == 0);
    @(negedge clk);

    // Hold the receiver off and keep offering back to back until the block
    // fills and stalls its input.
    idle_en   = 1'b0;
    long_hold = 1'b1;
    rot = $urandom_range(0, 2047);
    for (int k = 0; k < FILL_ITEMS; k++) begin
      rot = rot + $urandom_range(0, 40) - 20;
      send_pair(wiper_shape(rot), wiper_shape(rot + 512));
    end

    // Random segments: mostly smooth rotations, some noise and corners.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_en = (sent < RANDOM_ITEMS - QUIET_ITEMS);
      seg_len = $urandom_range(8, 40);
      case ($urandom_range(0, 9))
        0, 1:    seg = SEG_UNIFORM;
        2:       seg = SEG_CORNER;
        default: seg = SEG_ROTATE;
      endcase
      for (int k = 0; k < seg_len; k++) begin
        case (seg)
          SEG_ROTATE: begin
            // advance by a random signed amount, sometimes a fast spin
            if ($urandom_range(0, 7) == 0) rot = rot + $urandom_range(0, 600) - 300;
            else                           rot = rot + $urandom_range(0, 40) - 20;
            a = wiper_shape(rot);
            b = wiper_shape(rot + 512);
          end
          SEG_UNIFORM: begin
            a = WIPER_W'($urandom_range(0, 1023));
            b = WIPER_W'($urandom_range(0, 1023));
          end
          default: begin
            a = corner_value();
            b = corner_value();
          end
        endcase
        send_pair(a, b);
        sent++;
      end
    end

    // Drain and give the verdict.
    in_valid <= 1'b0;
    wait (decodes_in_flight == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("endless_pot_decoder_tb: done, clean");
    end else begin
      $display("endless_pot_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
